[rtl/gtpe_pkg.sv]
`default_nettype none
package gtpe_pkg;

	localparam int MAX_TILES_DEF = 32;
	localparam int MAX_GRID_DEF  = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

	localparam logic [4:0] GRID_COLUMNS_RESET = 5'd4;
	localparam logic [4:0] GRID_ROWS_RESET    = 5'd3;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_CHECK  = 3'd2;
	localparam logic [2:0] CMD_FIND   = 3'd3;
	localparam logic [2:0] CMD_LOOKUP = 3'd4;

	typedef struct packed {
		logic [15:0] id;
		logic [3:0]  col;
		logic [3:0]  row;
		logic [4:0]  col_span;
		logic [4:0]  row_span;
	} entry_t;

	typedef struct packed {
		logic load;
		logic clear_tab;
		logic insert;
		logic walk_start;
		logic walk_run;
		logic pos_next;
		logic mark_found;
		logic publish;
	} ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       bnd_fail;
		logic       first_ok;
		logic       pos_last;
		logic       walk_end;
		logic       hit;
	} sts_t;

endpackage
`default_nettype wire

[rtl/gtpe_req_if.sv]
`default_nettype none
interface gtpe_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	logic [15:0]       tile_id;
	logic signed [5:0] col;
	logic signed [5:0] row;
	logic [4:0]        col_span;
	logic [4:0]        row_span;
	logic              use_exclude;

	modport source (
		output valid, cmd, tile_id, col, row, col_span, row_span, use_exclude,
		input  ready
	);
	modport sink (
		input  valid, cmd, tile_id, col, row, col_span, row_span, use_exclude,
		output ready
	);
endinterface
`default_nettype wire

[rtl/gtpe_rsp_if.sv]
`default_nettype none
interface gtpe_rsp_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       collides;
	logic       found;
	logic [3:0] found_col;
	logic [3:0] found_row;
	logic [4:0] found_col_span;
	logic [4:0] found_row_span;

	modport source (
		output valid, status, collides, found, found_col, found_row,
		       found_col_span, found_row_span,
		input  ready
	);
	modport sink (
		input  valid, status, collides, found, found_col, found_row,
		       found_col_span, found_row_span,
		output ready
	);
endinterface
`default_nettype wire

[rtl/grid_tile_placement_engine.sv]
// Channel  Dir  Payload
// req      in   cmd, tile_id, col, row, col_span, row_span, use_exclude
// rsp      out  status, collides, found, found_col, found_row, spans
// cfg      in   cfg_we, cfg_idx, cfg_wdata (write only)
//
// Clear and insert act in the dispatch state and publish their result from the response state.
// Check and lookup walk the stored tiles; the tile table, with separate write and
// read ports, delivers one entry per cycle and a walk stops at the first match.
// Find repeats that walk for each tried position.
// A new request beat is taken once the previous result is in the output register.
// Reset clears the table count and restores the grid size; no clearing pass.
`default_nettype none
module grid_tile_placement_engine #(
	parameter int MAX_TILES = gtpe_pkg::MAX_TILES_DEF,
	parameter int MAX_GRID  = gtpe_pkg::MAX_GRID_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gtpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [gtpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	gtpe_req_if.sink                             req,
	gtpe_rsp_if.source                           rsp
);

	gtpe_pkg::ctl_t ctl;
	gtpe_pkg::sts_t sts;

	gtpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	gtpe_datapath #(
		.MAX_TILES(MAX_TILES),
		.MAX_GRID (MAX_GRID)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_wdata         (cfg_wdata),
		.in_cmd            (req.cmd),
		.in_tile_id        (req.tile_id),
		.in_col            (req.col),
		.in_row            (req.row),
		.in_col_span       (req.col_span),
		.in_row_span       (req.row_span),
		.in_use_exclude    (req.use_exclude),
		.ctl               (ctl),
		.sts               (sts),
		.out_status        (rsp.status),
		.out_collides      (rsp.collides),
		.out_found         (rsp.found),
		.out_found_col     (rsp.found_col),
		.out_found_row     (rsp.found_row),
		.out_found_col_span(rsp.found_col_span),
		.out_found_row_span(rsp.found_row_span)
	);

endmodule
`default_nettype wire

[rtl/gtpe_ram.sv]
`default_nettype none
module gtpe_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/gtpe_datapath.sv]
`default_nettype none
module gtpe_datapath #(
	parameter int MAX_TILES = gtpe_pkg::MAX_TILES_DEF,
	parameter int MAX_GRID  = gtpe_pkg::MAX_GRID_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gtpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [gtpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [2:0]                      in_cmd,
	input  wire logic [15:0]                     in_tile_id,
	input  wire logic signed [5:0]               in_col,
	input  wire logic signed [5:0]               in_row,
	input  wire logic [4:0]                      in_col_span,
	input  wire logic [4:0]                      in_row_span,
	input  wire logic                            in_use_exclude,
	input  wire gtpe_pkg::ctl_t                  ctl,
	output gtpe_pkg::sts_t                       sts,
	output logic                                 out_status,
	output logic                                 out_collides,
	output logic                                 out_found,
	output logic [3:0]                           out_found_col,
	output logic [3:0]                           out_found_row,
	output logic [4:0]                           out_found_col_span,
	output logic [4:0]                           out_found_row_span
);

	localparam int CW = $clog2(MAX_TILES + 1);
	localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int EW = $bits(gtpe_pkg::entry_t);

	logic [4:0]        gcols_q, grows_q;
	logic [2:0]        cmd_q;
	logic [15:0]       id_q;
	logic signed [5:0] c_q, r_q;
	logic [4:0]        cs_q, rs_q;
	logic              skip_q;
	logic [CW-1:0]     count_q, idx_q;
	logic              vld_s1, hit_q, found_q, full_q;
	logic [4:0]        x_q, y_q;
	gtpe_pkg::entry_t  ent_q;

	logic [4:0]        gc, gr;
	logic signed [7:0] c8, r8, cs8, rs8, gc8, gr8, ce8, re8;
	logic signed [7:0] ax8, ay8, ae8, be8, tc8, tr8, te8, tbe8;
	logic              bnd_fail, overlap, id_eq, match_s1, issue, walk_end;
	logic [6:0]        nx, ny;
	logic              col_more, row_more, ram_we;
	gtpe_pkg::entry_t  wr_ent, rd_ent;
	logic [EW-1:0]     rd_raw;

	assign gc = (int'(gcols_q) > MAX_GRID) ? 5'(MAX_GRID) : gcols_q;
	assign gr = (int'(grows_q) > MAX_GRID) ? 5'(MAX_GRID) : grows_q;

	assign c8  = signed'({{2{c_q[5]}}, c_q});
	assign r8  = signed'({{2{r_q[5]}}, r_q});
	assign cs8 = signed'({3'b000, cs_q});
	assign rs8 = signed'({3'b000, rs_q});
	assign gc8 = signed'({3'b000, gc});
	assign gr8 = signed'({3'b000, gr});
	assign ce8 = c8 + cs8;
	assign re8 = r8 + rs8;
	assign bnd_fail = c_q[5] || r_q[5] || (ce8 > gc8) || (re8 > gr8);

	assign rd_ent = gtpe_pkg::entry_t'(rd_raw);
	assign ax8  = (cmd_q == gtpe_pkg::CMD_FIND) ? signed'({3'b000, x_q}) : c8;
	assign ay8  = (cmd_q == gtpe_pkg::CMD_FIND) ? signed'({3'b000, y_q}) : r8;
	assign ae8  = ax8 + cs8;
	assign be8  = ay8 + rs8;
	assign tc8  = signed'({4'b0000, rd_ent.col});
	assign tr8  = signed'({4'b0000, rd_ent.row});
	assign te8  = tc8 + signed'({3'b000, rd_ent.col_span});
	assign tbe8 = tr8 + signed'({3'b000, rd_ent.row_span});
	assign overlap = !((ae8 <= tc8) || (te8 <= ax8) || (be8 <= tr8) || (tbe8 <= ay8));
	assign id_eq = (rd_ent.id == id_q);

	always_comb begin
		case (cmd_q)
			gtpe_pkg::CMD_LOOKUP: match_s1 = vld_s1 && id_eq;
			gtpe_pkg::CMD_CHECK:  match_s1 = vld_s1 && overlap && !(skip_q && id_eq);
			gtpe_pkg::CMD_FIND:   match_s1 = vld_s1 && overlap;
			default:              match_s1 = 1'b0;
		endcase
	end

	assign issue = ctl.walk_run && !ctl.walk_start && (idx_q < count_q) &&
	               !hit_q && !match_s1;
	assign walk_end = hit_q || (!vld_s1 && (idx_q == count_q));

	assign nx = {2'b00, x_q} + 7'd1 + {2'b00, cs_q};
	assign ny = {2'b00, y_q} + 7'd1 + {2'b00, rs_q};
	assign col_more = (nx <= {2'b00, gc});
	assign row_more = (ny <= {2'b00, gr});

	assign sts.cmd      = cmd_q;
	assign sts.bnd_fail = bnd_fail;
	assign sts.first_ok = (cs_q <= gc) && (rs_q <= gr);
	assign sts.pos_last = !col_more && !row_more;
	assign sts.walk_end = walk_end;
	assign sts.hit      = hit_q;

	assign ram_we = ctl.insert && (count_q != CW'(MAX_TILES));
	assign wr_ent.id       = id_q;
	assign wr_ent.col      = c_q[3:0];
	assign wr_ent.row      = r_q[3:0];
	assign wr_ent.col_span = cs_q;
	assign wr_ent.row_span = rs_q;

	gtpe_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_TILES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(wr_ent),
		.re   (issue),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcols_q <= gtpe_pkg::GRID_COLUMNS_RESET;
			grows_q <= gtpe_pkg::GRID_ROWS_RESET;
			count_q <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			hit_q   <= 1'b0;
			found_q <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			if (cfg_we && (cfg_idx == gtpe_pkg::REG_GRID_COLUMNS)) begin
				gcols_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_idx == gtpe_pkg::REG_GRID_ROWS)) begin
				grows_q <= cfg_wdata;
			end
			if (ctl.load) begin
				hit_q   <= 1'b0;
				found_q <= 1'b0;
				full_q  <= 1'b0;
				vld_s1  <= 1'b0;
			end else if (ctl.walk_start) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
				hit_q  <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (match_s1) begin
					hit_q <= 1'b1;
				end
			end
			if (ctl.clear_tab) begin
				count_q <= '0;
			end
			if (ctl.insert) begin
				if (ram_we) begin
					count_q <= count_q + CW'(1);
				end else begin
					full_q <= 1'b1;
				end
			end
			if (ctl.mark_found) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_cmd;
			id_q   <= in_tile_id;
			c_q    <= in_col;
			r_q    <= in_row;
			cs_q   <= in_col_span;
			rs_q   <= in_row_span;
			skip_q <= in_use_exclude;
			x_q    <= '0;
			y_q    <= '0;
		end else if (ctl.pos_next) begin
			if (col_more) begin
				x_q <= x_q + 5'd1;
			end else begin
				x_q <= '0;
				y_q <= y_q + 5'd1;
			end
		end
		if (match_s1 && !hit_q && !ctl.walk_start) begin
			ent_q <= rd_ent;
		end
		if (ctl.publish) begin
			out_status         <= (cmd_q == gtpe_pkg::CMD_INSERT) && full_q;
			out_collides       <= (cmd_q == gtpe_pkg::CMD_CHECK) && (bnd_fail || hit_q);
			out_found          <= 1'b0;
			out_found_col      <= '0;
			out_found_row      <= '0;
			out_found_col_span <= '0;
			out_found_row_span <= '0;
			if ((cmd_q == gtpe_pkg::CMD_FIND) && found_q) begin
				out_found     <= 1'b1;
				out_found_col <= x_q[3:0];
				out_found_row <= y_q[3:0];
			end
			if ((cmd_q == gtpe_pkg::CMD_LOOKUP) && hit_q) begin
				out_found          <= 1'b1;
				out_found_col      <= ent_q.col;
				out_found_row      <= ent_q.row;
				out_found_col_span <= ent_q.col_span;
				out_found_row_span <= ent_q.row_span;
			end
		end
	end

`ifndef ASSERT_OFF
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.insert && (count_q != CW'(MAX_TILES))) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert into a table with room did not grow the count");
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(ctl.walk_run))
		else $error("table read data arrived outside a walk");
	a_hit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q && ctl.walk_run && !ctl.walk_start && !ctl.load) |=> hit_q)
		else $error("hit flag dropped in the middle of a walk");
	a_no_walk_out_of_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.publish && (cmd_q == gtpe_pkg::CMD_CHECK) && bnd_fail) |-> !hit_q)
		else $error("out-of-grid check walked the table");
`endif

endmodule
`default_nettype wire

[rtl/gtpe_ctrl.sv]
`default_nettype none
module gtpe_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	input  wire gtpe_pkg::sts_t sts,
	output gtpe_pkg::ctl_t      ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_WALK,
		S_RESP
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_vld_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_RESP;
				case (sts.cmd)
					gtpe_pkg::CMD_CLEAR: ctl.clear_tab = 1'b1;
					gtpe_pkg::CMD_INSERT: ctl.insert = 1'b1;
					gtpe_pkg::CMD_CHECK: begin
						if (!sts.bnd_fail) begin
							ctl.walk_start = 1'b1;
							state_d        = S_WALK;
						end
					end
					gtpe_pkg::CMD_FIND: begin
						if (sts.first_ok) begin
							ctl.walk_start = 1'b1;
							state_d        = S_WALK;
						end
					end
					gtpe_pkg::CMD_LOOKUP: begin
						ctl.walk_start = 1'b1;
						state_d        = S_WALK;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_WALK: begin
				ctl.walk_run = 1'b1;
				if (sts.walk_end) begin
					state_d = S_RESP;
					if (sts.cmd == gtpe_pkg::CMD_FIND) begin
						if (!sts.hit) begin
							ctl.mark_found = 1'b1;
						end else if (!sts.pos_last) begin
							ctl.pos_next   = 1'b1;
							ctl.walk_start = 1'b1;
							state_d        = S_WALK;
						end
					end
				end
			end
			S_RESP: begin
				if (!out_vld_q || rsp_ready) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.publish) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
